[hdl/assert_macros.svh]
// Assertion macros shared by the scanner RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds at an edge -> post holds at the same edge
`define AM_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// pre holds at an edge -> post holds at the next edge
`define AM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/lmps_pkg.sv]
// Types, constants and PWM lookup for the LED matrix PWM scanner.
// No dependencies.
`default_nettype none

package lmps_pkg;

  localparam int ROWS      = 8;
  localparam int COLUMNS   = 8;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ROW_SLOTS = 2 ** ROW_W;
  localparam int BANKS     = 2;
  localparam int ADDR_W    = ROW_W + 1;
  localparam int MEM_DEPTH = BANKS * ROW_SLOTS;
  localparam int FRAME_W   = 32;
  localparam int DRIVE_W   = 16;

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [1:0]       LEVEL_MAX = 2'd3;

  // bit p of entry l: column on at level l, phase p
  localparam logic [3:0] PWM_TABLE [4] = '{4'b0000, 4'b0001, 4'b0101, 4'b1111};

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_SET_BOTH  = 3'd1,
    MODE_SET_RED   = 3'd2,
    MODE_SET_GREEN = 3'd3,
    MODE_ADD_RED   = 3'd4,
    MODE_ADD_GREEN = 3'd5,
    MODE_SWAP      = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] pixel_column;
    logic [2:0] pixel_row;
    logic [1:0] red_value;
    logic [1:0] green_value;
  } in_word_t;

  typedef struct packed {
    logic               scan_valid;
    logic [2:0]         row_index;
    logic [DRIVE_W-1:0] column_drive;
    logic [1:0]         read_red;
    logic [1:0]         read_green;
  } out_word_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [FRAME_W-1:0] data;
  } fs_write_t;

  typedef struct packed {
    logic en;
    logic bank;
  } fs_clear_t;

  function automatic logic pwm_bit(input logic [1:0] level, input logic [1:0] phase);
    return PWM_TABLE[level][phase];
  endfunction

  function automatic logic [1:0] sat_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[2] ? LEVEL_MAX : sum[1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/lmps_frame_store.sv]
// Double-buffered frame store: one write port, two registered read ports with
// write-through, and per-row valid bits so a bank clear need not rewrite memory. Uses lmps_pkg.
`default_nettype none

module lmps_frame_store (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [lmps_pkg::ADDR_W-1:0]   rd_addr_a,
  input  wire  [lmps_pkg::ADDR_W-1:0]   rd_addr_b,
  output logic [lmps_pkg::FRAME_W-1:0]  rd_data_a,
  output logic [lmps_pkg::FRAME_W-1:0]  rd_data_b,
  input  wire  lmps_pkg::fs_write_t     wr,
  input  wire  lmps_pkg::fs_clear_t     clr
);

  `include "assert_macros.svh"

  logic [lmps_pkg::FRAME_W-1:0] mem [lmps_pkg::MEM_DEPTH];

  logic [lmps_pkg::BANKS-1:0][lmps_pkg::ROW_SLOTS-1:0] valid_r;
  logic [lmps_pkg::FRAME_W-1:0] rd_a_r;
  logic [lmps_pkg::FRAME_W-1:0] rd_b_r;
  logic va_r, va_nxt;
  logic vb_r, vb_nxt;
  logic hit_a, hit_b;

  assign hit_a = wr.en && (wr.addr == rd_addr_a);
  assign hit_b = wr.en && (wr.addr == rd_addr_b);

  always_comb begin
    if (hit_a) begin
      va_nxt = 1'b1;
    end else if (clr.en && (clr.bank == rd_addr_a[lmps_pkg::ADDR_W-1])) begin
      va_nxt = 1'b0;
    end else begin
      va_nxt = valid_r[rd_addr_a[lmps_pkg::ADDR_W-1]][rd_addr_a[lmps_pkg::ROW_W-1:0]];
    end
    if (hit_b) begin
      vb_nxt = 1'b1;
    end else if (clr.en && (clr.bank == rd_addr_b[lmps_pkg::ADDR_W-1])) begin
      vb_nxt = 1'b0;
    end else begin
      vb_nxt = valid_r[rd_addr_b[lmps_pkg::ADDR_W-1]][rd_addr_b[lmps_pkg::ROW_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // write-through so a read in the cycle of a write sees the new word
  always_ff @(posedge clk) begin
    if (hit_a) begin
      rd_a_r <= wr.data;
    end else begin
      rd_a_r <= mem[rd_addr_a];
    end
    if (hit_b) begin
      rd_b_r <= wr.data;
    end else begin
      rd_b_r <= mem[rd_addr_b];
    end
    va_r <= va_nxt;
    vb_r <= vb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr[lmps_pkg::ADDR_W-1]][wr.addr[lmps_pkg::ROW_W-1:0]] <= 1'b1;
    end else if (clr.en) begin
      valid_r[clr.bank] <= '0;
    end
  end

  assign rd_data_a = va_r ? rd_a_r : '0;
  assign rd_data_b = vb_r ? rd_b_r : '0;

  `AM_ASSERT_IMP(a_fs_one_op, clk, rst_n, wr.en, !clr.en)

endmodule

`default_nettype wire

[hdl/led_matrix_pwm_scanner_unit.sv]
// Top level of the LED matrix PWM scanner.
// Uses lmps_pkg, lmps_frame_store and assert_macros.svh.
`default_nettype none

// One word is taken on every clock at which start is high; busy is low at all
// times outside reset. Every word gives exactly one result on out_word, shown
// for a single cycle: the word is registered in the s1 stage, and out_strobe
// and out_word are then registered together from it. The receiver cannot hold
// results off. The frame store is read in the accept cycle and written back in
// the next, with write-through covering back-to-back words, so throughput is
// one word per clock. Bank clears zero the per-row valid bits, not the rows;
// there is no clearing pass after reset.
module led_matrix_pwm_scanner_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire lmps_pkg::in_word_t  in_word,
  output logic                     out_strobe,
  output lmps_pkg::out_word_t      out_word
);

  `include "assert_macros.svh"

  logic accept;

  logic                       front_select_r, front_select_nxt;
  logic [lmps_pkg::ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [1:0]                 pwm_phase_r, pwm_phase_nxt;

  logic                        back_bank;
  logic [lmps_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [lmps_pkg::FRAME_W-1:0] rd_front, rd_back;
  logic                        pix_in_range;

  logic                        s1_vld_r;
  lmps_pkg::mode_t             s1_mode_r;
  logic [2:0]                  s1_col_r;
  logic                        s1_inside_r;
  logic [1:0]                  s1_red_r, s1_green_r;
  logic [1:0]                  s1_phase_r;
  logic [lmps_pkg::ROW_W-1:0]  s1_scan_row_r;
  logic [lmps_pkg::ADDR_W-1:0] s1_addr_r;

  lmps_pkg::fs_write_t wr;
  lmps_pkg::fs_clear_t clr;

  logic [4:0]                   red_sh;
  logic [1:0]                   old_r, old_g, new_r, new_g;
  logic                         pix_write;
  logic [lmps_pkg::FRAME_W-1:0] word_nxt;

  logic                out_strobe_r;
  lmps_pkg::out_word_t out_word_r, out_word_nxt;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  // front/scan state moves at accept so the next word addresses correctly
  always_comb begin
    front_select_nxt = front_select_r;
    scan_row_nxt     = scan_row_r;
    pwm_phase_nxt    = pwm_phase_r;
    if (accept) begin
      case (in_word.mode)
        lmps_pkg::MODE_TICK: begin
          if (scan_row_r == lmps_pkg::ROW_LAST) begin
            scan_row_nxt  = '0;
            pwm_phase_nxt = pwm_phase_r + 2'd1;
          end else begin
            scan_row_nxt = scan_row_r + lmps_pkg::ROW_W'(1);
          end
        end
        lmps_pkg::MODE_SWAP: front_select_nxt = ~front_select_r;
        default: ;
      endcase
    end
  end

  assign back_bank = (in_word.mode == lmps_pkg::MODE_SWAP) ? front_select_r : ~front_select_r;
  assign rd_addr_a = {front_select_r, scan_row_r};
  assign rd_addr_b = {back_bank, lmps_pkg::ROW_W'(in_word.pixel_row)};
  assign pix_in_range = (4'(in_word.pixel_column) < 4'(lmps_pkg::COLUMNS)) &&
                        (5'(in_word.pixel_row) < 5'(lmps_pkg::ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_select_r <= 1'b0;
      scan_row_r     <= '0;
      pwm_phase_r    <= '0;
      s1_vld_r       <= 1'b0;
      out_strobe_r   <= 1'b0;
    end else begin
      front_select_r <= front_select_nxt;
      scan_row_r     <= scan_row_nxt;
      pwm_phase_r    <= pwm_phase_nxt;
      s1_vld_r       <= accept;
      out_strobe_r   <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r     <= in_word.mode;
      s1_col_r      <= in_word.pixel_column;
      s1_inside_r   <= pix_in_range;
      s1_red_r      <= in_word.red_value;
      s1_green_r    <= in_word.green_value;
      s1_phase_r    <= pwm_phase_r;
      s1_scan_row_r <= scan_row_r;
      s1_addr_r     <= rd_addr_b;
    end
    out_word_r <= out_word_nxt;
  end

  lmps_frame_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_front),
    .rd_data_b (rd_back),
    .wr        (wr),
    .clr       (clr)
  );

  // pixel read-modify-write on the back word
  always_comb begin
    red_sh = {s1_col_r, 2'b00};
    old_r  = rd_back[red_sh +: 2];
    old_g  = rd_back[red_sh + 5'd2 +: 2];
    new_r  = old_r;
    new_g  = old_g;
    case (s1_mode_r)
      lmps_pkg::MODE_SET_BOTH: begin
        new_r = s1_red_r;
        new_g = s1_green_r;
      end
      lmps_pkg::MODE_SET_RED:   new_r = s1_red_r;
      lmps_pkg::MODE_SET_GREEN: new_g = s1_green_r;
      lmps_pkg::MODE_ADD_RED:   new_r = lmps_pkg::sat_add(old_r, s1_red_r);
      lmps_pkg::MODE_ADD_GREEN: new_g = lmps_pkg::sat_add(old_g, s1_green_r);
      default: ;
    endcase
    pix_write = s1_vld_r && s1_inside_r &&
                (s1_mode_r inside {lmps_pkg::MODE_SET_BOTH, lmps_pkg::MODE_SET_RED,
                                   lmps_pkg::MODE_SET_GREEN, lmps_pkg::MODE_ADD_RED,
                                   lmps_pkg::MODE_ADD_GREEN});
    word_nxt = rd_back;
    word_nxt[red_sh +: 2]        = new_r;
    word_nxt[red_sh + 5'd2 +: 2] = new_g;
  end

  assign wr  = '{en: pix_write, addr: s1_addr_r, data: word_nxt};
  assign clr = '{en: s1_vld_r && (s1_mode_r == lmps_pkg::MODE_CLEAR),
                 bank: s1_addr_r[lmps_pkg::ADDR_W-1]};

  always_comb begin
    out_word_nxt              = '0;
    out_word_nxt.column_drive = '1;
    if (s1_mode_r == lmps_pkg::MODE_TICK) begin
      out_word_nxt.scan_valid = 1'b1;
      out_word_nxt.row_index  = 3'(s1_scan_row_r);
      for (int i = 0; i < lmps_pkg::COLUMNS; i++) begin
        out_word_nxt.column_drive[2*i]   = ~lmps_pkg::pwm_bit(rd_front[4*i+2 +: 2], s1_phase_r);
        out_word_nxt.column_drive[2*i+1] = ~lmps_pkg::pwm_bit(rd_front[4*i +: 2], s1_phase_r);
      end
    end
    if (s1_inside_r && (s1_mode_r != lmps_pkg::MODE_CLEAR)) begin
      out_word_nxt.read_red   = new_r;
      out_word_nxt.read_green = new_g;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `AM_ASSERT_IMP(a_idle_drive_off, clk, rst_n, out_strobe && !out_word.scan_valid, out_word.column_drive == '1 && out_word.row_index == '0)
  `AM_ASSERT_NEXT(a_row_wrap, clk, rst_n, accept && in_word.mode == lmps_pkg::MODE_TICK && scan_row_r == lmps_pkg::ROW_LAST, scan_row_r == '0 && pwm_phase_r == $past(pwm_phase_r) + 2'd1)
  `AM_ASSERT_NEXT(a_swap_flips, clk, rst_n, accept && in_word.mode == lmps_pkg::MODE_SWAP, front_select_r != $past(front_select_r))
  `AM_ASSERT_NEXT(a_clear_reads_zero, clk, rst_n, s1_vld_r && s1_mode_r == lmps_pkg::MODE_CLEAR, out_strobe && out_word.read_red == '0 && out_word.read_green == '0)

endmodule

`default_nettype wire

[sim/tb_led_matrix_pwm_scanner_unit.sv]
// Self-checking bench for led_matrix_pwm_scanner_unit: directed and random command words.
// Carries its own model of the frame banks, scan row and PWM phase. Depends on lmps_pkg.
`timescale 1ns / 100ps

module tb_led_matrix_pwm_scanner_unit;

  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASE_WORDS = 200;

  typedef struct {
    lmps_pkg::in_word_t word;
    int                 gap_pct;
  } cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  lmps_pkg::in_word_t  in_word = '0;
  logic                out_strobe;
  lmps_pkg::out_word_t out_word;

  cmd_t                cmd_queue[$];
  lmps_pkg::out_word_t expected_scans[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;

  // model state
  logic [31:0] frame_rows [16];
  logic        shown_bank = 1'b0;
  logic [2:0]  scan_row = '0;
  logic [1:0]  pwm_phase = '0;

  led_matrix_pwm_scanner_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic level_lit(logic [1:0] level, logic [1:0] phase);
    case (level)
      2'd0: return 1'b0;
      2'd1: return phase == 2'd0;
      2'd2: return !phase[0];
      default: return 1'b1;
    endcase
  endfunction

  function automatic lmps_pkg::out_word_t model_scan_step(lmps_pkg::in_word_t w);
    lmps_pkg::out_word_t res;
    logic [31:0] row_bits;
    logic [15:0] lit;
    logic [3:0]  back_idx;
    logic [4:0]  base;
    logic [1:0]  red_lvl;
    logic [1:0]  grn_lvl;
    res = '0;
    res.column_drive = 16'hFFFF;
    base = {w.pixel_column, 2'b00};
    back_idx = {~shown_bank, w.pixel_row};
    case (w.mode)
      lmps_pkg::MODE_TICK: begin
        row_bits = frame_rows[{shown_bank, scan_row}];
        lit = '0;
        for (int i = 0; i < 8; i++) begin
          lit[2*i]   = level_lit(row_bits[4*i+2 +: 2], pwm_phase);
          lit[2*i+1] = level_lit(row_bits[4*i +: 2], pwm_phase);
        end
        res.scan_valid = 1'b1;
        res.row_index = scan_row;
        res.column_drive = ~lit;
        if (scan_row == 3'd7) pwm_phase = pwm_phase + 2'd1;
        scan_row = scan_row + 3'd1;
      end
      lmps_pkg::MODE_SWAP: shown_bank = ~shown_bank;
      lmps_pkg::MODE_CLEAR: begin
        for (int i = 0; i < 8; i++) frame_rows[{~shown_bank, 3'(i)}] = '0;
      end
      default: begin
        row_bits = frame_rows[back_idx];
        red_lvl = row_bits[base +: 2];
        grn_lvl = row_bits[base + 5'd2 +: 2];
        case (w.mode)
          lmps_pkg::MODE_SET_BOTH: begin
            red_lvl = w.red_value;
            grn_lvl = w.green_value;
          end
          lmps_pkg::MODE_SET_RED:   red_lvl = w.red_value;
          lmps_pkg::MODE_SET_GREEN: grn_lvl = w.green_value;
          lmps_pkg::MODE_ADD_RED:
            red_lvl = ({1'b0, red_lvl} + w.red_value > 3) ? 2'd3 : red_lvl + w.red_value;
          default:
            grn_lvl = ({1'b0, grn_lvl} + w.green_value > 3) ? 2'd3 : grn_lvl + w.green_value;
        endcase
        row_bits[base +: 2] = red_lvl;
        row_bits[base + 5'd2 +: 2] = grn_lvl;
        frame_rows[back_idx] = row_bits;
      end
    endcase
    back_idx = {~shown_bank, w.pixel_row};
    res.read_red = frame_rows[back_idx][base +: 2];
    res.read_green = frame_rows[back_idx][base + 5'd2 +: 2];
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic queue_cmd(lmps_pkg::mode_t mode, int x, int y, int r, int g, int gap);
    cmd_t c;
    c.word.mode = mode;
    c.word.pixel_column = 3'(x);
    c.word.pixel_row = 3'(y);
    c.word.red_value = 2'(r);
    c.word.green_value = 2'(g);
    c.gap_pct = gap;
    cmd_queue.push_back(c);
  endtask

  task automatic queue_random(lmps_pkg::mode_t mode, int gap);
    queue_cmd(mode, $urandom_range(7), $urandom_range(7), $urandom_range(3),
              $urandom_range(3), gap);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_scans.push_back(model_scan_step(in_word));
      void'(cmd_queue.pop_front());
    end
    if (rst_n && cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].gap_pct) begin
      start <= 1'b1;
      in_word <= cmd_queue[0].word;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_scans.size() == 0) begin
        flag_mismatch("result with no word pending", out_word.column_drive, 16'h0);
      end else begin
        lmps_pkg::out_word_t want;
        want = expected_scans.pop_front();
        if (out_word.scan_valid !== want.scan_valid)
          flag_mismatch("scan_valid", out_word.scan_valid, want.scan_valid);
        if (out_word.row_index !== want.row_index)
          flag_mismatch("row_index", out_word.row_index, want.row_index);
        if (out_word.column_drive !== want.column_drive)
          flag_mismatch("column_drive", out_word.column_drive, want.column_drive);
        if (out_word.read_red !== want.read_red)
          flag_mismatch("read_red", out_word.read_red, want.read_red);
        if (out_word.read_green !== want.read_green)
          flag_mismatch("read_green", out_word.read_green, want.read_green);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("led_matrix_pwm_scanner_unit verification failed");
      $finish;
    end
  end

  initial begin
    int gaps[4];
    int made;
    int pick;
    int n;
    gaps = '{0, 48, 0, 24};
    for (int i = 0; i < 16; i++) frame_rows[i] = '0;

    // directed
    queue_cmd(lmps_pkg::MODE_TICK, 0, 0, 0, 0, 0);
    queue_cmd(lmps_pkg::MODE_SET_BOTH, 0, 0, 3, 3, 0);
    queue_cmd(lmps_pkg::MODE_SET_BOTH, 7, 7, 3, 3, 0);
    queue_cmd(lmps_pkg::MODE_SET_RED, 1, 0, 2, 3, 0);
    queue_cmd(lmps_pkg::MODE_SET_GREEN, 2, 0, 3, 1, 0);
    queue_cmd(lmps_pkg::MODE_ADD_RED, 0, 0, 3, 0, 0);
    queue_cmd(lmps_pkg::MODE_ADD_GREEN, 7, 7, 0, 2, 0);
    queue_cmd(lmps_pkg::MODE_ADD_RED, 1, 0, 1, 0, 0);
    queue_cmd(lmps_pkg::MODE_ADD_GREEN, 2, 0, 0, 1, 0);
    queue_cmd(lmps_pkg::MODE_SET_BOTH, 3, 0, 1, 2, 0);
    queue_cmd(lmps_pkg::MODE_SWAP, 7, 7, 3, 3, 0);
    for (int i = 0; i < 8; i++) queue_random(lmps_pkg::MODE_TICK, 0);
    queue_cmd(lmps_pkg::MODE_SET_BOTH, 5, 5, 3, 3, 0);
    queue_cmd(lmps_pkg::MODE_CLEAR, 5, 5, 0, 0, 0);
    queue_cmd(lmps_pkg::MODE_SET_BOTH, 6, 6, 0, 0, 0);
    queue_cmd(lmps_pkg::MODE_SWAP, 0, 0, 0, 0, 0);
    queue_cmd(lmps_pkg::MODE_TICK, 0, 0, 0, 0, 0);

    // random: paint, swap, clear and scan bursts with some noise
    for (int ph = 0; ph < 4; ph++) begin
      made = 0;
      while (made < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          n = $urandom_range(10, 2);
          for (int i = 0; i < n; i++)
            queue_random(lmps_pkg::mode_t'($urandom_range(5, 1)), gaps[ph]);
        end else if (pick < 75) begin
          n = $urandom_range(20, 1);
          for (int i = 0; i < n; i++) queue_random(lmps_pkg::MODE_TICK, gaps[ph]);
        end else if (pick < 85) begin
          n = 1;
          queue_random(lmps_pkg::MODE_SWAP, gaps[ph]);
        end else if (pick < 89) begin
          n = 1;
          queue_random(lmps_pkg::MODE_CLEAR, gaps[ph]);
        end else begin
          n = $urandom_range(4, 1);
          for (int i = 0; i < n; i++)
            queue_random(lmps_pkg::mode_t'($urandom_range(7)), gaps[ph]);
        end
        made += n;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (cmd_queue.size() != 0 || expected_scans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("led_matrix_pwm_scanner_unit verification clean");
    end else begin
      $display("led_matrix_pwm_scanner_unit verification failed");
    end
    $finish;
  end

endmodule

[led_matrix_pwm_scanner_unit.f]
+incdir+hdl
hdl/lmps_pkg.sv
hdl/lmps_frame_store.sv
hdl/led_matrix_pwm_scanner_unit.sv
sim/tb_led_matrix_pwm_scanner_unit.sv
